FILE: hdl/jbp_pkg.sv
// Package for the JPEG bit packer: command codes, queue entry and serializer step types.
// Used by the top level, front, queue and back modules; depends on nothing.
package jbp_pkg;

	typedef enum logic [1:0] {
		CMD_APPEND = 2'd0,
		CMD_FLUSH  = 2'd1,
		CMD_RAW    = 2'd2,
		CMD_NONE   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		STEP_B0 = 2'd0,
		STEP_S0 = 2'd1,
		STEP_B1 = 2'd2,
		STEP_S1 = 2'd3
	} step_t;

	// One or two bytes to send; raw entries carry one byte and skip stuffing
	typedef struct packed {
		logic       raw;
		logic       two;
		logic [7:0] byte0;
		logic [7:0] byte1;
	} entry_t;

	localparam logic [7:0] BYTE_FF   = 8'hFF;
	localparam logic [7:0] BYTE_STUF = 8'h00;
	localparam int         WORD_W    = 16;

endpackage

FILE: hdl/jpeg_bit_packer_with_stuffing.sv
// Top level of the JPEG entropy bit packer with 0xFF byte stuffing.
// Depends on jbp_pkg, jbp_front, jbp_queue, jbp_back.
//
//   channel | signals                              | dir | beat
//   input   | in_valid in_ready cmd code_bits      | in  | one command
//           | code_len byte_value                  |     |
//   output  | out_valid out_ready out_byte last    | out | one stream byte
//
// A command is accepted whenever the queue is not full; the front holds no stall of its own beyond a full queue.
// The back sends one byte per cycle while out_ready allows, so an entry drains as one to four bytes.
// Sustained input rate is one command per cycle while stuffed output fits the output slots.
// Reset clears the holding register, the queue pointers and count, and the output valid flag.
// A stalled output fills the queue, then in_ready drops.
module jpeg_bit_packer_with_stuffing #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  cmd,
	input  logic [15:0] code_bits,
	input  logic [4:0]  code_len,
	input  logic [7:0]  byte_value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_byte,
	output logic        last
);

	jbp_pkg::entry_t push_entry;
	jbp_pkg::entry_t head;
	logic            push;
	logic            pop;
	logic            q_full;
	logic            q_empty;

	jbp_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.cmd        (cmd),
		.code_bits  (code_bits),
		.code_len   (code_len),
		.byte_value (byte_value),
		.q_full     (q_full),
		.push       (push),
		.push_entry (push_entry)
	);

	jbp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.full       (q_full),
		.empty      (q_empty)
	);

	jbp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.empty     (q_empty),
		.pop       (pop),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_byte  (out_byte),
		.last      (last)
	);

endmodule

FILE: hdl/jbp_front.sv
// Front part: accepts commands, packs code bits into the holding register, forms byte entries.
// Depends on jbp_pkg.
module jbp_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [1:0]           cmd,
	input  logic [15:0]          code_bits,
	input  logic [4:0]           code_len,
	input  logic [7:0]           byte_value,
	input  logic                 q_full,
	output logic                 push,
	output jbp_pkg::entry_t      push_entry
);

	logic [15:0] pend_bits_q;
	logic [3:0]  pend_cnt_q;
	logic [15:0] pend_bits_d;
	logic [3:0]  pend_cnt_d;
	logic [4:0]  len_sat;
	logic [3:0]  align_sh;
	logic [15:0] aligned;
	logic [31:0] ext;
	logic [4:0]  total;
	logic [15:0] word;
	logic [15:0] padded;
	logic        emit;
	logic        accept;

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	always_comb begin
		len_sat  = (code_len > 5'd16) ? 5'd16 : code_len;
		align_sh = 4'((5'd16 - len_sat));
		aligned  = code_bits << align_sh;
		ext      = {aligned, 16'h0000} >> pend_cnt_q;
		total    = {1'b0, pend_cnt_q} + len_sat;
		word     = pend_bits_q | ext[31:16];
		padded   = pend_bits_q | (16'hFFFF >> pend_cnt_q);
	end

	always_comb begin
		emit             = 1'b0;
		push_entry.raw   = 1'b0;
		push_entry.two   = 1'b0;
		push_entry.byte0 = word[15:8];
		push_entry.byte1 = word[7:0];
		pend_bits_d      = pend_bits_q;
		pend_cnt_d       = pend_cnt_q;
		case (jbp_pkg::cmd_t'(cmd))
			jbp_pkg::CMD_APPEND: begin
				if (len_sat != 5'd0) begin
					pend_cnt_d = total[3:0];
					if (total[4]) begin
						emit           = 1'b1;
						push_entry.two = 1'b1;
						pend_bits_d    = ext[15:0];
					end else begin
						pend_bits_d = word;
					end
				end
			end
			jbp_pkg::CMD_FLUSH: begin
				push_entry.byte0 = padded[15:8];
				push_entry.byte1 = padded[7:0];
				emit             = (pend_cnt_q != 4'd0);
				push_entry.two   = (pend_cnt_q > 4'd8);
				pend_bits_d      = 16'h0000;
				pend_cnt_d       = 4'd0;
			end
			jbp_pkg::CMD_RAW: begin
				emit             = 1'b1;
				push_entry.raw   = 1'b1;
				push_entry.byte0 = byte_value;
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	assign push = accept && emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_bits_q <= 16'h0000;
			pend_cnt_q  <= 4'd0;
		end else if (accept) begin
			pend_bits_q <= pend_bits_d;
			pend_cnt_q  <= pend_cnt_d;
		end
	end

endmodule

FILE: hdl/jbp_queue.sv
// Short entry queue between front and back parts.
// Depends on jbp_pkg.
module jbp_queue #(
	parameter int DEPTH = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  jbp_pkg::entry_t push_entry,
	input  logic            pop,
	output jbp_pkg::entry_t head,
	output logic            full,
	output logic            empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	jbp_pkg::entry_t mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   cnt_q;
	logic            do_push;
	logic            do_pop;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

FILE: hdl/jbp_back.sv
// Back part: walks each queue entry byte by byte, inserts stuffed zeros, drives the output register.
// Depends on jbp_pkg.
module jbp_back (
	input  logic            clk,
	input  logic            arst_n,
	input  jbp_pkg::entry_t head,
	input  logic            empty,
	output logic            pop,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [7:0]      out_byte,
	output logic            last
);

	jbp_pkg::step_t step_q;
	jbp_pkg::step_t step_d;
	logic           has_s0;
	logic           has_b1;
	logic           has_s1;
	logic           is_last;
	logic [7:0]     cur_byte;
	logic           load;
	logic           out_valid_q;
	logic [7:0]     out_byte_q;
	logic           last_q;

	assign has_s0 = !head.raw && (head.byte0 == jbp_pkg::BYTE_FF);
	assign has_b1 = head.two;
	assign has_s1 = head.two && !head.raw && (head.byte1 == jbp_pkg::BYTE_FF);
	assign load   = !empty && (!out_valid_q || out_ready);
	assign pop    = load && is_last;

	// next step
	always_comb begin
		step_d  = jbp_pkg::STEP_B0;
		is_last = 1'b1;
		case (step_q)
			jbp_pkg::STEP_B0: begin
				if (has_s0) begin
					step_d  = jbp_pkg::STEP_S0;
					is_last = 1'b0;
				end else if (has_b1) begin
					step_d  = jbp_pkg::STEP_B1;
					is_last = 1'b0;
				end
			end
			jbp_pkg::STEP_S0: begin
				if (has_b1) begin
					step_d  = jbp_pkg::STEP_B1;
					is_last = 1'b0;
				end
			end
			jbp_pkg::STEP_B1: begin
				if (has_s1) begin
					step_d  = jbp_pkg::STEP_S1;
					is_last = 1'b0;
				end
			end
			default: begin
				step_d  = jbp_pkg::STEP_B0;
				is_last = 1'b1;
			end
		endcase
	end

	// byte for the current step
	always_comb begin
		case (step_q)
			jbp_pkg::STEP_B0: cur_byte = head.byte0;
			jbp_pkg::STEP_B1: cur_byte = head.byte1;
			default:          cur_byte = jbp_pkg::BYTE_STUF;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= jbp_pkg::STEP_B0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				step_q      <= step_d;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q <= cur_byte;
			last_q     <= is_last;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign last      = last_q;

endmodule

FILE: hdl/jbp_checker.sv
// Port-level checker for the JPEG bit packer, bound to the top level.
// Depends on jpeg_bit_packer_with_stuffing ports only.
module jbp_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [7:0]  out_byte,
	input logic        last
);

	logic       out_beat;
	logic       stuff_due_q;
	logic [1:0] beat_cnt_q;

	assign out_beat = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stuff_due_q <= 1'b0;
			beat_cnt_q  <= 2'd0;
		end else if (out_beat) begin
			stuff_due_q <= (out_byte == 8'hFF) && !last;
			beat_cnt_q  <= last ? 2'd0 : beat_cnt_q + 2'd1;
		end
	end

	// hold a stalled output beat
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(last))
		else $error("output beat changed while stalled");

	// stuffed zero after a data 0xFF
	a_stuff: assert property (@(posedge clk) disable iff (!arst_n)
		out_beat && stuff_due_q |-> out_byte == 8'h00)
		else $error("missing stuffed zero after 0xFF");

	// at most four bytes per command
	a_max_beats: assert property (@(posedge clk) disable iff (!arst_n)
		out_beat && beat_cnt_q == 2'd3 |-> last)
		else $error("more than four bytes for one command");

	// a stuffed zero is never the first byte of a command
	a_stuff_not_last_ff: assert property (@(posedge clk) disable iff (!arst_n)
		out_beat && stuff_due_q |-> beat_cnt_q != 2'd0)
		else $error("stuffed zero opens a command");

endmodule

bind jpeg_bit_packer_with_stuffing jbp_checker u_jbp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_byte  (out_byte),
	.last      (last)
);

FILE: test/jbp_tb_pkg.sv
`timescale 1ns / 100ps
// Scoreboard for the JPEG bit packer bench: predicts the stuffed byte stream per command.
// Depends on jbp_pkg for command codes and stuffing constants.
package jbp_tb_pkg;

	typedef struct {
		logic [7:0] data;
		logic       last;
	} stream_byte_t;

	class stream_scoreboard;
		logic [15:0]  held_bits;
		int           held_count;
		stream_byte_t expected_bytes[$];
		int           errors;

		function new();
			held_bits  = '0;
			held_count = 0;
			errors     = 0;
		endfunction

		function void queue_byte(logic [7:0] b, bit stuffed);
			stream_byte_t sb;
			sb.data = b;
			sb.last = 1'b0;
			expected_bytes.push_back(sb);
			if (stuffed && b == jbp_pkg::BYTE_FF) begin
				sb.data = jbp_pkg::BYTE_STUF;
				expected_bytes.push_back(sb);
			end
		endfunction

		function void take_command(logic [1:0] c, logic [15:0] code, logic [4:0] len,
				logic [7:0] val);
			int          start;
			int          n;
			int          total;
			int          rem;
			int          pad;
			int          i;
			logic [31:0] code32;
			logic [31:0] word;
			start = expected_bytes.size();
			case (jbp_pkg::cmd_t'(c))
				jbp_pkg::CMD_APPEND: begin
					if (len != 0) begin
						n = (len > 16) ? 16 : int'(len);
						code32 = {16'h0, code} & ((32'h1 << n) - 32'h1);
						total = held_count + n;
						if (total >= jbp_pkg::WORD_W) begin
							rem = total - jbp_pkg::WORD_W;
							word = {16'h0, held_bits} | (code32 >> rem);
							queue_byte(word[15:8], 1'b1);
							queue_byte(word[7:0], 1'b1);
							held_bits = (rem == 0) ? 16'h0 :
								16'(code32 << (jbp_pkg::WORD_W - rem));
							held_count = rem;
						end else begin
							held_bits = held_bits | 16'(code32 << (jbp_pkg::WORD_W - total));
							held_count = total;
						end
					end
				end
				jbp_pkg::CMD_FLUSH: begin
					word = {16'h0, held_bits};
					total = held_count;
					if (total % 8 != 0) begin
						pad = 8 - (total % 8);
						word = word | (((32'h1 << pad) - 32'h1) <<
							(jbp_pkg::WORD_W - total - pad));
						total = total + pad;
					end
					for (i = 0; i < total / 8; i++)
						queue_byte(8'(word >> (8 - 8 * i)), 1'b1);
					held_bits  = '0;
					held_count = 0;
				end
				jbp_pkg::CMD_RAW: begin
					queue_byte(val, 1'b0);
				end
				default: begin
				end
			endcase
			if (expected_bytes.size() > start)
				expected_bytes[expected_bytes.size() - 1].last = 1'b1;
		endfunction

		function void check_byte(logic [7:0] b, logic l);
			stream_byte_t want;
			if (expected_bytes.size() == 0) begin
				$error("out_byte: expected none, actual %h", b);
				errors++;
				return;
			end
			want = expected_bytes.pop_front();
			if (b !== want.data) begin
				$error("out_byte: expected %h, actual %h", want.data, b);
				errors++;
			end
			if (l !== want.last) begin
				$error("last: expected %b, actual %b", want.last, l);
				errors++;
			end
		endfunction

		function int outstanding();
			return expected_bytes.size();
		endfunction
	endclass

endpackage

FILE: test/tb.sv
`timescale 1ns / 100ps
// Testbench top for jpeg_bit_packer_with_stuffing: directed and random commands, bursty input.
// Depends on jbp_pkg, jbp_tb_pkg and the packer RTL.
module tb;

	logic        clk        = 1'b0;
	logic        arst_n     = 1'b0;
	logic        in_valid   = 1'b0;
	logic        in_ready;
	logic [1:0]  cmd        = '0;
	logic [15:0] code_bits  = '0;
	logic [4:0]  code_len   = '0;
	logic [7:0]  byte_value = '0;
	logic        out_valid;
	logic        out_ready  = 1'b0;
	logic [7:0]  out_byte;
	logic        last;

	jbp_tb_pkg::stream_scoreboard sb = new();
	int accepted_items = 0;
	int burst_left     = 0;
	bit held_off       = 1'b0;

	jpeg_bit_packer_with_stuffing u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.cmd       (cmd),
		.code_bits (code_bits),
		.code_len  (code_len),
		.byte_value(byte_value),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_byte  (out_byte),
		.last      (last)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready) begin
			sb.take_command(cmd, code_bits, code_len, byte_value);
			accepted_items++;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_byte(out_byte, last);
	end

	initial begin
		int seg_len;
		int mode;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if (!held_off && accepted_items >= 60) begin
				held_off = 1'b1;
				out_ready <= 1'b0;
				repeat (80) @(posedge clk);
			end
			seg_len = $urandom_range(4, 32);
			mode = $urandom_range(0, 2);
			repeat (seg_len) begin
				if (mode == 0)
					out_ready <= 1'b1;
				else if (mode == 1)
					out_ready <= ($urandom_range(0, 3) != 0);
				else
					out_ready <= ($urandom_range(0, 2) == 0);
				@(posedge clk);
			end
		end
	end

	task automatic offer(input logic [1:0] c, input logic [15:0] code, input logic [4:0] len,
			input logic [7:0] val);
		in_valid   <= 1'b1;
		cmd        <= c;
		code_bits  <= code;
		code_len   <= len;
		byte_value <= val;
		do @(posedge clk); while (!in_ready);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = $urandom_range(0, 15);
		end
	endtask

	task automatic drain_stream();
		in_valid <= 1'b0;
		do @(posedge clk); while (sb.outstanding() != 0);
	endtask

	initial begin
		int          counted;
		int          r;
		bit          paused;
		logic [1:0]  c;
		logic [15:0] code;
		logic [4:0]  len;
		logic [7:0]  val;
		counted = 0;
		paused  = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		offer(jbp_pkg::CMD_APPEND, 16'hFFFE, 5'd1, 8'h00);
		offer(jbp_pkg::CMD_APPEND, 16'hFFFF, 5'd16, 8'hFF);
		offer(jbp_pkg::CMD_APPEND, 16'hABCD, 5'd0, 8'h5A);
		offer(jbp_pkg::CMD_APPEND, 16'h1234, 5'd31, 8'hA5);
		offer(jbp_pkg::CMD_APPEND, 16'hFF00, 5'd17, 8'h0F);
		offer(jbp_pkg::CMD_FLUSH, 16'hFFFF, 5'd31, 8'hFF);
		offer(jbp_pkg::CMD_FLUSH, 16'h0000, 5'd0, 8'h00);
		offer(jbp_pkg::CMD_APPEND, 16'h00FF, 5'd8, 8'h11);
		offer(jbp_pkg::CMD_FLUSH, 16'h5555, 5'd10, 8'h22);
		offer(jbp_pkg::CMD_APPEND, 16'h0005, 5'd3, 8'h33);
		offer(jbp_pkg::CMD_RAW, 16'h0000, 5'd0, jbp_pkg::BYTE_FF);
		offer(jbp_pkg::CMD_APPEND, 16'h001F, 5'd5, 8'h44);
		offer(jbp_pkg::CMD_RAW, 16'hFFFF, 5'd31, 8'h00);
		offer(jbp_pkg::CMD_NONE, 16'hFFFF, 5'd31, 8'hFF);
		offer(jbp_pkg::CMD_FLUSH, 16'h0000, 5'd0, 8'h00);
		offer(jbp_pkg::CMD_APPEND, 16'h0000, 5'd16, 8'h00);
		offer(jbp_pkg::CMD_APPEND, 16'hFFFF, 5'd16, 8'h00);
		offer(jbp_pkg::CMD_APPEND, 16'h007F, 5'd7, 8'h00);
		offer(jbp_pkg::CMD_FLUSH, 16'h0000, 5'd0, 8'h00);
		offer(jbp_pkg::CMD_APPEND, 16'h0ABC, 5'd12, 8'h00);
		offer(jbp_pkg::CMD_FLUSH, 16'h0000, 5'd0, 8'h00);
		offer(jbp_pkg::CMD_RAW, 16'h0000, 5'd0, 8'hD9);

		while (counted < 328) begin
			r    = $urandom_range(0, 99);
			code = 16'($urandom);
			len  = 5'($urandom);
			val  = 8'($urandom);
			if (r < 60) begin
				c = jbp_pkg::CMD_APPEND;
				len = 5'($urandom_range(1, 16));
				if ($urandom_range(0, 6) == 0)
					code = 16'hFFFF;
			end else if (r < 72) begin
				c = jbp_pkg::CMD_FLUSH;
			end else if (r < 82) begin
				c = jbp_pkg::CMD_RAW;
				if ($urandom_range(0, 4) == 0)
					val = jbp_pkg::BYTE_FF;
			end else if (r < 86) begin
				c = jbp_pkg::CMD_NONE;
			end else if (r < 90) begin
				c = jbp_pkg::CMD_APPEND;
				len = 5'd0;
			end else begin
				c = jbp_pkg::CMD_APPEND;
				len = 5'($urandom_range(17, 31));
			end
			offer(c, code, len, val);
			counted++;
			if (!paused && counted >= 180) begin
				paused = 1'b1;
				drain_stream();
			end
		end

		drain_stream();
		repeat (40) @(posedge clk);
		if (sb.errors == 0 && sb.outstanding() == 0)
			$display("jpeg_bit_packer_with_stuffing: match");
		else
			$display("jpeg_bit_packer_with_stuffing: mismatch");
		$finish;
	end

	initial begin
		#2000000;
		$display("jpeg_bit_packer_with_stuffing: mismatch");
		$finish;
	end

endmodule

FILE: files.f
hdl/jbp_pkg.sv
hdl/jbp_front.sv
hdl/jbp_queue.sv
hdl/jbp_back.sv
hdl/jpeg_bit_packer_with_stuffing.sv
hdl/jbp_checker.sv
test/jbp_tb_pkg.sv
test/tb.sv
